// ----- rtl/core/dmfp_pkg.sv -----
// Shared types and constants for the DNS message field parser.
package dmfp_pkg;

  localparam int unsigned HEADER_BYTES   = 12;
  localparam int unsigned QUESTION_BYTES = 4;
  localparam int unsigned ANSWER_BYTES   = 12;

  localparam logic [7:0]  MAX_NAME_CHARS      = 8'd255;
  localparam logic [15:0] QTYPE_RESET         = 16'd28;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_UNIMPL   = 2'd1,
    ST_EARLY    = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] message_id;
    logic        is_response;
    logic [3:0]  response_code;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [7:0]  name_length;
    logic [15:0] question_type;
    logic [15:0] question_class;
    logic [15:0] answer_type;
    logic [31:0] answer_ttl;
    logic [15:0] answer_data_length;
    status_t     status;
  } summary_t;

endpackage

// ----- rtl/core/dmfp_parse.sv -----
// Byte-wise parse state of one DNS message and the summary formed on its last byte.
module dmfp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         message_byte,
  input  logic               last_byte,
  input  logic [15:0]        qtype_cfg,
  output dmfp_pkg::summary_t summary
);
  import dmfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_QUESTION,
    PH_ANSWER,
    PH_DONE_OK,
    PH_DONE_UNIMPL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [7:0]  label_r, label_nxt;
  logic [7:0]  name_r, name_nxt;

  // Only the header bytes that feed a result field are kept.
  logic [7:0]  hdr_r   [8];
  logic [7:0]  hdr_nxt [8];
  logic [7:0]  q_r     [4];
  logic [7:0]  q_nxt   [4];
  logic [15:0] atype_r, atype_nxt;
  logic [31:0] attl_r, attl_nxt;
  logic [15:0] alen_r, alen_nxt;

  logic [3:0]  fidx_inc;
  logic [15:0] qt_w;
  logic [15:0] an_w;
  logic [3:0]  hcnt, qcnt, acnt;

  assign fidx_inc = fidx_r + 4'd1;
  // The type bytes are already registered when the last question byte arrives.
  assign qt_w     = {q_r[0], q_r[1]};
  assign an_w     = {hdr_r[6], hdr_r[7]};

  always_comb begin
    phase_nxt = phase_r;
    fidx_nxt  = fidx_r;
    label_nxt = label_r;
    name_nxt  = name_r;
    hdr_nxt   = hdr_r;
    q_nxt     = q_r;
    atype_nxt = atype_r;
    attl_nxt  = attl_r;
    alen_nxt  = alen_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (fidx_r < 4'd8) begin
          hdr_nxt[fidx_r[2:0]] = message_byte;
        end
        fidx_nxt = fidx_inc;
        if (fidx_inc >= 4'(HEADER_BYTES)) begin
          phase_nxt = PH_NAME;
          fidx_nxt  = 4'd0;
        end
      end
      PH_NAME: begin
        if (label_r == 8'd0) begin
          if (message_byte == 8'd0) begin
            phase_nxt = PH_QUESTION;
            fidx_nxt  = 4'd0;
          end else begin
            // A new label after the first one adds its separating dot.
            if (name_r != 8'd0 && name_r < MAX_NAME_CHARS) begin
              name_nxt = name_r + 8'd1;
            end
            label_nxt = message_byte;
          end
        end else begin
          label_nxt = label_r - 8'd1;
          if (name_r < MAX_NAME_CHARS) begin
            name_nxt = name_r + 8'd1;
          end
        end
      end
      PH_QUESTION: begin
        q_nxt[fidx_r[1:0]] = message_byte;
        fidx_nxt = fidx_inc;
        if (fidx_inc >= 4'(QUESTION_BYTES)) begin
          fidx_nxt = 4'd0;
          if (qt_w != qtype_cfg) begin
            phase_nxt = PH_DONE_UNIMPL;
          end else if (an_w != 16'd0) begin
            phase_nxt = PH_ANSWER;
          end else begin
            phase_nxt = PH_DONE_OK;
          end
        end
      end
      PH_ANSWER: begin
        unique case (fidx_r)
          4'd2:    atype_nxt[15:8] = message_byte;
          4'd3:    atype_nxt[7:0]  = message_byte;
          4'd6:    attl_nxt[31:24] = message_byte;
          4'd7:    attl_nxt[23:16] = message_byte;
          4'd8:    attl_nxt[15:8]  = message_byte;
          4'd9:    attl_nxt[7:0]   = message_byte;
          4'd10:   alen_nxt[15:8]  = message_byte;
          4'd11:   alen_nxt[7:0]   = message_byte;
          default: ;
        endcase
        fidx_nxt = fidx_inc;
        if (fidx_inc >= 4'(ANSWER_BYTES)) begin
          phase_nxt = PH_DONE_OK;
        end
      end
      default: ;
    endcase
  end

  // Byte counts of each fixed section after this byte; fields not yet complete read as zero.
  always_comb begin
    hcnt = (phase_nxt == PH_HEADER) ? fidx_nxt : 4'(HEADER_BYTES);
    priority if (phase_nxt == PH_HEADER || phase_nxt == PH_NAME) begin
      qcnt = 4'd0;
    end else if (phase_nxt == PH_QUESTION) begin
      qcnt = fidx_nxt;
    end else begin
      qcnt = 4'(QUESTION_BYTES);
    end
    priority if (phase_nxt == PH_ANSWER) begin
      acnt = fidx_nxt;
    end else if (phase_nxt == PH_DONE_OK || phase_nxt == PH_DONE_UNIMPL) begin
      acnt = 4'(ANSWER_BYTES);
    end else begin
      acnt = 4'd0;
    end
  end

  always_comb begin
    summary.message_id     = (hcnt >= 4'd2) ? {hdr_nxt[0], hdr_nxt[1]} : 16'd0;
    summary.is_response    = (hcnt >= 4'd3) ? hdr_nxt[2][7] : 1'b0;
    summary.response_code  = (hcnt >= 4'd4) ? hdr_nxt[3][3:0] : 4'd0;
    summary.question_count = (hcnt >= 4'd6) ? {hdr_nxt[4], hdr_nxt[5]} : 16'd0;
    summary.answer_count   = (hcnt >= 4'd8) ? {hdr_nxt[6], hdr_nxt[7]} : 16'd0;
    summary.name_length    = name_nxt;
    summary.question_type  = (qcnt >= 4'd2) ? {q_nxt[0], q_nxt[1]} : 16'd0;
    summary.question_class = (qcnt >= 4'd4) ? {q_nxt[2], q_nxt[3]} : 16'd0;
    // An unimplemented type skips the answer, so those fields stay zero.
    summary.answer_type        = (phase_nxt != PH_DONE_UNIMPL && acnt >= 4'd4) ?
                                 atype_nxt : 16'd0;
    summary.answer_ttl         = (phase_nxt != PH_DONE_UNIMPL && acnt >= 4'd10 &&
                                  (phase_nxt == PH_ANSWER || an_w != 16'd0)) ?
                                 attl_nxt : 32'd0;
    summary.answer_data_length = (phase_nxt != PH_DONE_UNIMPL && acnt >= 4'd12 &&
                                  (phase_nxt == PH_ANSWER || an_w != 16'd0)) ?
                                 alen_nxt : 16'd0;
    if (phase_nxt == PH_DONE_UNIMPL || (phase_nxt == PH_DONE_OK && an_w == 16'd0)) begin
      summary.answer_type = 16'd0;
    end
    unique case (phase_nxt)
      PH_DONE_OK:     summary.status = ST_ACCEPTED;
      PH_DONE_UNIMPL: summary.status = ST_UNIMPL;
      default:        summary.status = ST_EARLY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      fidx_r  <= 4'd0;
      label_r <= 8'd0;
      name_r  <= 8'd0;
    end else if (accept) begin
      if (last_byte) begin
        phase_r <= PH_HEADER;
        fidx_r  <= 4'd0;
        label_r <= 8'd0;
        name_r  <= 8'd0;
      end else begin
        phase_r <= phase_nxt;
        fidx_r  <= fidx_nxt;
        label_r <= label_nxt;
        name_r  <= name_nxt;
      end
    end
  end

  // Field bytes are always gated by the section counts, so they need no clearing.
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r   <= hdr_nxt;
      q_r     <= q_nxt;
      atype_r <= atype_nxt;
      attl_r  <= attl_nxt;
      alen_r  <= alen_nxt;
    end
  end

endmodule

// ----- rtl/core/dmfp_out.sv -----
// Result register of the parser with its valid/stall handshake.
module dmfp_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  dmfp_pkg::summary_t summary,
  input  logic               out_stall,
  output logic               out_valid,
  output dmfp_pkg::summary_t result
);
  import dmfp_pkg::*;

  logic     valid_r, valid_nxt;
  summary_t data_r;

  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= summary;
    end
  end

  assign out_valid = valid_r;
  assign result    = data_r;

endmodule

// ----- rtl/core/dns_message_field_parser.sv -----
// Top level of the DNS message field parser: byte parser, result register, config register.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_message_byte, in_last_byte
//   out_      output     out_valid/out_stall  header, question, answer fields, status
//   cfg_      input      cfg_write            cfg_accepted_query_type
//
// Each byte is taken when it is offered and not stalled; a summary appears in the cycle after the last byte.
// Bytes that are not the last are taken every cycle, even while a result waits.
// A last byte is held off only while the previous summary is still stalled.
// Synchronous active-low reset clears the parse state, the result valid and
// sets the accepted query type to 28.
module dns_message_field_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_message_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_message_id,
  output logic                  out_is_response,
  output logic [3:0]            out_response_code,
  output logic [15:0]           out_question_count,
  output logic [15:0]           out_answer_count,
  output logic [7:0]            out_name_length,
  output logic [15:0]           out_question_type,
  output logic [15:0]           out_question_class,
  output logic [15:0]           out_answer_type,
  output logic [31:0]           out_answer_ttl,
  output logic [15:0]           out_answer_data_length,
  output logic [1:0]            out_status,
  input  logic                  cfg_write,
  input  logic [15:0]           cfg_accepted_query_type
);
  import dmfp_pkg::*;

  logic [15:0] qtype_r;
  logic        accept;
  summary_t    summary;
  summary_t    result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qtype_r <= QTYPE_RESET;
    end else if (cfg_write) begin
      qtype_r <= cfg_accepted_query_type;
    end
  end

  assign in_stall = out_valid & out_stall & in_last_byte;
  assign accept   = in_valid & ~in_stall;

  dmfp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .message_byte (in_message_byte),
    .last_byte    (in_last_byte),
    .qtype_cfg    (qtype_r),
    .summary      (summary)
  );

  dmfp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept & in_last_byte),
    .summary   (summary),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_message_id         = result.message_id;
  assign out_is_response        = result.is_response;
  assign out_response_code      = result.response_code;
  assign out_question_count     = result.question_count;
  assign out_answer_count       = result.answer_count;
  assign out_name_length        = result.name_length;
  assign out_question_type      = result.question_type;
  assign out_question_class     = result.question_class;
  assign out_answer_type        = result.answer_type;
  assign out_answer_ttl         = result.answer_ttl;
  assign out_answer_data_length = result.answer_data_length;
  assign out_status             = result.status;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> out_valid)
    else $error("accepted last byte did not produce a result");

  a_mid_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_last_byte) |-> !in_stall)
    else $error("non-final byte was stalled");

  a_unimpl_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UNIMPL) |->
      (out_answer_type == 16'd0 && out_answer_ttl == 32'd0 &&
       out_answer_data_length == 16'd0))
    else $error("answer fields set on an unimplemented query type");
`endif

endmodule
